// File: rtl/core/emf_triggered_activation_sequencer_defines.svh
// ----------------------------------------------------------------------------
// EMF activation sequencer assertion macros
// Shared property macros for the checker of the activation sequencer.
// ----------------------------------------------------------------------------
`ifndef EMF_TRIGGERED_ACTIVATION_SEQUENCER_DEFINES_SVH
`define EMF_TRIGGERED_ACTIVATION_SEQUENCER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ETAS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ETAS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/etas_pkg.sv
// ----------------------------------------------------------------------------
// EMF activation sequencer package
// Widths, mode codes, register indexes, reset values and shared types.
// ----------------------------------------------------------------------------
package etas_pkg;

	localparam int DUR_W   = 20;
	localparam int VOL_W   = 5;
	localparam int TIME_W  = 22;
	localparam int BLINK_W = 10;
	localparam int MODE_W  = 2;
	localparam int CFG_IDX_W = 3;

	localparam logic [MODE_W-1:0] MODE_LISTEN = 2'd0;
	localparam logic [MODE_W-1:0] MODE_EMF    = 2'd1;
	localparam logic [MODE_W-1:0] MODE_SPIN   = 2'd2;
	localparam logic [MODE_W-1:0] MODE_ACT    = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_MIN_DETECT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SPINDOWN   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MUSIC      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RELAY_ON   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_VOLUME     = 3'd4;

	localparam logic [DUR_W-1:0] MIN_DETECT_RST = 20'd2000;
	localparam logic [DUR_W-1:0] SPINDOWN_RST   = 20'd5000;
	localparam logic [DUR_W-1:0] MUSIC_RST      = 20'd10000;
	localparam logic [DUR_W-1:0] RELAY_ON_RST   = 20'd3000;
	localparam logic [VOL_W-1:0] VOLUME_RST     = 5'd20;

	localparam logic [BLINK_W-1:0] BLINK_PERIOD_MS = 10'd1000;
	localparam logic [TIME_W-1:0]  RELAY_GAP_MS    = 22'd500;
	localparam logic [TIME_W-1:0]  TIME_MAX        = {TIME_W{1'b1}};

	typedef struct packed {
		logic [DUR_W-1:0] min_detect_ms;
		logic [DUR_W-1:0] spindown_ms;
		logic [DUR_W-1:0] music_ms;
		logic [DUR_W-1:0] relay_on_ms;
		logic [VOL_W-1:0] play_volume;
	} cfg_t;

	typedef struct packed {
		logic emf_present;
		logic override_press;
	} item_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic              power_led;
		logic              trigger_led;
		logic              relays_on;
		logic              music_start;
		logic              music_stop;
		logic [VOL_W-1:0]  volume;
	} result_t;

endpackage

// File: rtl/core/etas_cfg_regs.sv
// ----------------------------------------------------------------------------
// EMF activation sequencer configuration registers
// Holds the timing and volume registers written through the config channel.
// ----------------------------------------------------------------------------
module etas_cfg_regs import etas_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DUR_W-1:0]     cfg_data,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_detect_ms <= MIN_DETECT_RST;
			cfg_q.spindown_ms   <= SPINDOWN_RST;
			cfg_q.music_ms      <= MUSIC_RST;
			cfg_q.relay_on_ms   <= RELAY_ON_RST;
			cfg_q.play_volume   <= VOLUME_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_MIN_DETECT: cfg_q.min_detect_ms <= cfg_data;
				REG_SPINDOWN:   cfg_q.spindown_ms   <= cfg_data;
				REG_MUSIC:      cfg_q.music_ms      <= cfg_data;
				REG_RELAY_ON:   cfg_q.relay_on_ms   <= cfg_data;
				REG_VOLUME:     cfg_q.play_volume   <= cfg_data[VOL_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: rtl/core/etas_in_stage.sv
// ----------------------------------------------------------------------------
// EMF activation sequencer input stage
// Registers one tick item and holds it until the step logic consumes it.
// ----------------------------------------------------------------------------
module etas_in_stage import etas_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  item_valid,
	input  item_t item_in,
	input  logic  consume,
	output logic  item_stall,
	output logic  valid_s1,
	output item_t item_s1
);

	logic can_load;
	logic accept;

	assign can_load   = !valid_s1 || consume;
	assign accept     = item_valid && can_load;
	assign item_stall = !can_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (consume) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item_in;
		end
	end

endmodule

// File: rtl/core/etas_step.sv
// ----------------------------------------------------------------------------
// EMF activation sequencer step logic
// Mode state, timers and blink state, advanced by one tick per consumed item.
// ----------------------------------------------------------------------------
module etas_step import etas_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  item_t   item_s1,
	input  logic    step_en,
	output result_t result
);

	logic [MODE_W-1:0]  mode_q;
	logic [TIME_W-1:0]  time_q;
	logic               run_pending_q;
	logic [BLINK_W-1:0] blink_count_q;
	logic               blink_level_q;
	logic               relay_level_q;

	logic [MODE_W-1:0]  m;
	logic [TIME_W-1:0]  tm;
	logic               rp;
	logic [BLINK_W-1:0] bc;
	logic               bl;
	logic               rl;
	logic               p_start;
	logic               p_stop;

	logic [TIME_W-1:0] spin_lim;
	logic [TIME_W-1:0] music_lim;
	logic [TIME_W-1:0] on_at;
	logic [TIME_W-1:0] run_end;
	logic [TIME_W-1:0] min_det;

	assign spin_lim  = (cfg.spindown_ms == '0) ? TIME_W'(1) : TIME_W'(cfg.spindown_ms);
	assign music_lim = (cfg.music_ms == '0) ? TIME_W'(1) : TIME_W'(cfg.music_ms);
	assign on_at     = TIME_W'(cfg.music_ms) + RELAY_GAP_MS;
	assign run_end   = on_at + TIME_W'(cfg.relay_on_ms);
	assign min_det   = TIME_W'(cfg.min_detect_ms);

	always_comb begin
		m       = mode_q;
		tm      = (time_q == TIME_MAX) ? time_q : time_q + TIME_W'(1);
		rp      = run_pending_q;
		bc      = blink_count_q;
		bl      = blink_level_q;
		rl      = relay_level_q;
		p_start = 1'b0;
		p_stop  = 1'b0;

		if (m == MODE_SPIN) begin
			if (tm == spin_lim) begin
				m       = MODE_ACT;
				tm      = '0;
				rl      = 1'b0;
				p_start = 1'b1;
			end else begin
				bc = bc + BLINK_W'(1);
				if (bc >= BLINK_PERIOD_MS) begin
					bc = '0;
					bl = !bl;
				end
			end
		end else if (m == MODE_ACT) begin
			if (tm == music_lim) begin
				p_stop = 1'b1;
			end
			if (tm == on_at) begin
				rl = 1'b1;
			end
			if (tm == run_end) begin
				rp     = 1'b0;
				m      = MODE_LISTEN;
				tm     = '0;
				rl     = 1'b0;
				p_stop = 1'b1;
			end
		end

		if (item_s1.override_press && m != MODE_ACT) begin
			m       = MODE_ACT;
			tm      = '0;
			rl      = 1'b0;
			p_start = 1'b1;
		end

		case (m)
			MODE_LISTEN: begin
				if (item_s1.emf_present) begin
					m  = MODE_EMF;
					tm = '0;
				end
			end
			MODE_EMF: begin
				if (!item_s1.emf_present) begin
					if (tm > min_det || rp) begin
						rp = 1'b1;
						m  = MODE_SPIN;
						bc = '0;
						bl = 1'b0;
					end else begin
						m = MODE_LISTEN;
					end
					tm = '0;
				end
			end
			default: begin
				if (item_s1.emf_present) begin
					if (m == MODE_ACT) begin
						rl     = 1'b0;
						p_stop = 1'b1;
					end
					m  = MODE_EMF;
					tm = '0;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= MODE_LISTEN;
			time_q        <= '0;
			run_pending_q <= 1'b0;
			blink_count_q <= '0;
			blink_level_q <= 1'b0;
			relay_level_q <= 1'b0;
		end else if (step_en) begin
			mode_q        <= m;
			time_q        <= tm;
			run_pending_q <= rp;
			blink_count_q <= bc;
			blink_level_q <= bl;
			relay_level_q <= rl;
		end
	end

	always_comb begin
		result.mode        = m;
		result.power_led   = (m == MODE_LISTEN) || (m == MODE_SPIN);
		result.trigger_led = (m == MODE_SPIN) ? bl : (m != MODE_LISTEN);
		result.relays_on   = rl;
		result.music_start = p_start;
		result.music_stop  = p_stop;
		result.volume      = p_start ? cfg.play_volume : '0;
	end

endmodule

// File: rtl/core/etas_out_stage.sv
// ----------------------------------------------------------------------------
// EMF activation sequencer output stage
// Result register that holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module etas_out_stage import etas_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  result_t result,
	input  logic    result_stall,
	output logic    ready,
	output logic    valid_s2,
	output result_t result_s2
);

	assign ready = !valid_s2 || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready) begin
			valid_s2 <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_s2 <= result;
		end
	end

endmodule

// File: rtl/core/emf_triggered_activation_sequencer.sv
// ----------------------------------------------------------------------------
// EMF-triggered activation sequencer
// Each accepted item is one millisecond tick carrying the EMF detector level
// and an override event; each tick yields exactly one result with the mode,
// the LED and relay levels, the music start and stop pulses and the volume.
// A new tick is accepted every clock cycle while item_stall is low; it is
// held in the input register, then the mode and timer update writes the
// result register that drives the outputs. Stalls on the result side back
// up through the input register to item_stall. Configuration registers are
// written through the cfg channel, which is always ready; writes to indexes
// beyond the volume register are ignored.
// ----------------------------------------------------------------------------
module emf_triggered_activation_sequencer import etas_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  logic                 emf_present,
	input  logic                 override_press,
	output logic                 result_valid,
	input  logic                 result_stall,
	output logic [MODE_W-1:0]    mode,
	output logic                 power_led,
	output logic                 trigger_led,
	output logic                 relays_on,
	output logic                 music_start,
	output logic                 music_stop,
	output logic [VOL_W-1:0]     volume,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DUR_W-1:0]     cfg_data
);

	cfg_t    cfg;
	item_t   item_in;
	item_t   item_s1;
	logic    valid_s1;
	logic    out_ready;
	logic    step_en;
	result_t result;
	result_t result_s2;

	assign cfg_ready = 1'b1;
	assign item_in.emf_present    = emf_present;
	assign item_in.override_press = override_press;
	assign step_en = valid_s1 && out_ready;

	etas_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	etas_in_stage u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_in    (item_in),
		.consume    (step_en),
		.item_stall (item_stall),
		.valid_s1   (valid_s1),
		.item_s1    (item_s1)
	);

	etas_step u_step (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.item_s1 (item_s1),
		.step_en (step_en),
		.result  (result)
	);

	etas_out_stage u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (step_en),
		.result       (result),
		.result_stall (result_stall),
		.ready        (out_ready),
		.valid_s2     (result_valid),
		.result_s2    (result_s2)
	);

	assign mode        = result_s2.mode;
	assign power_led   = result_s2.power_led;
	assign trigger_led = result_s2.trigger_led;
	assign relays_on   = result_s2.relays_on;
	assign music_start = result_s2.music_start;
	assign music_stop  = result_s2.music_stop;
	assign volume      = result_s2.volume;

endmodule

// File: rtl/core/etas_checker.sv
// ----------------------------------------------------------------------------
// EMF activation sequencer checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "emf_triggered_activation_sequencer_defines.svh"

module etas_checker import etas_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              result_valid,
	input logic              result_stall,
	input logic [MODE_W-1:0] mode,
	input logic              power_led,
	input logic              trigger_led,
	input logic              relays_on,
	input logic              music_start,
	input logic              music_stop,
	input logic [VOL_W-1:0]  volume
);

	logic        res_held;
	logic [12:0] res_all;
	logic        no_start;
	logic        relay_out;
	logic        in_act;
	logic        led_chk;
	logic        led_ok;

	assign res_held  = result_valid && result_stall;
	assign res_all   = {result_valid, mode, power_led, trigger_led, relays_on,
		music_start, music_stop, volume};
	assign no_start  = result_valid && !music_start;
	assign relay_out = result_valid && relays_on;
	assign in_act    = (mode == MODE_ACT);
	assign led_chk   = result_valid && (mode == MODE_LISTEN || mode == MODE_EMF);
	assign led_ok    = (power_led == (mode == MODE_LISTEN)) && (trigger_led == (mode == MODE_EMF));

	`ETAS_ASSERT_NXT(a_result_hold, clk, arst_n, res_held, $stable(res_all), "Held result changed.")
	`ETAS_ASSERT_IMP(a_volume_pulse, clk, arst_n, no_start, volume == '0, "Volume without start.")
	`ETAS_ASSERT_IMP(a_relay_mode, clk, arst_n, relay_out, in_act, "Relays on outside activation.")
	`ETAS_ASSERT_IMP(a_led_mode, clk, arst_n, led_chk, led_ok, "LED levels do not match the mode.")

endmodule

bind emf_triggered_activation_sequencer etas_checker u_etas_checker (.*);

// File: tb/tb_emf_triggered_activation_sequencer.sv
// ----------------------------------------------------------------------------
// Testbench for the EMF-triggered activation sequencer
// Millisecond ticks are driven through the item channel while the result
// channel is stalled at random. Every accepted tick is run through a local
// copy of the mode, timer, LED and relay behavior, and each result is checked
// field by field in order. The timer registers are changed between phases,
// from all zero to all ones, and one long quiet stretch lets an activation
// run through its music and relay timers back to listening.
// ----------------------------------------------------------------------------
module tb_emf_triggered_activation_sequencer import etas_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_AFTER_RESULTS = 300;
	localparam int HOLD_CYCLES = 250;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = {CFG_IDX_W{1'b1}};

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 item_valid = 1'b0;
	logic                 item_stall;
	logic                 emf_present = 1'b0;
	logic                 override_press = 1'b0;
	logic                 result_valid;
	logic                 result_stall = 1'b0;
	logic [MODE_W-1:0]    mode;
	logic                 power_led;
	logic                 trigger_led;
	logic                 relays_on;
	logic                 music_start;
	logic                 music_stop;
	logic [VOL_W-1:0]     volume;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = REG_MIN_DETECT;
	logic [DUR_W-1:0]     cfg_data = '0;

	// Local copy of the configuration and of the sequencer state.
	logic [DUR_W-1:0]   min_detect_cfg = MIN_DETECT_RST;
	logic [DUR_W-1:0]   spindown_cfg = SPINDOWN_RST;
	logic [DUR_W-1:0]   music_cfg = MUSIC_RST;
	logic [DUR_W-1:0]   relay_on_cfg = RELAY_ON_RST;
	logic [VOL_W-1:0]   volume_cfg = VOLUME_RST;
	logic [MODE_W-1:0]  cur_mode = MODE_LISTEN;
	logic [TIME_W-1:0]  ms_in_mode = '0;
	logic               run_pending = 1'b0;
	logic [BLINK_W-1:0] blink_ms = '0;
	logic               blink_on = 1'b0;
	logic               relay_on = 1'b0;
	logic               start_pulse = 1'b0;
	logic               stop_pulse = 1'b0;

	item_t   tick_q[$];
	result_t tick_out_q[$];
	item_t   next_tick;
	result_t want;

	int errors = 0;
	int results_seen = 0;
	int cycles = 0;
	int idle_pct = 17;
	int hold_left = 0;
	int ticks_made = 0;
	bit hold_done = 1'b0;
	bit item_taken = 1'b0;

	emf_triggered_activation_sequencer DUT (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.emf_present(emf_present),
		.override_press(override_press),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.mode(mode),
		.power_led(power_led),
		.trigger_led(trigger_led),
		.relays_on(relays_on),
		.music_start(music_start),
		.music_stop(music_stop),
		.volume(volume),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	function automatic logic timer_hits(input logic [TIME_W-1:0] t,
			input logic [TIME_W-1:0] dur);
		return t == ((dur == '0) ? TIME_W'(1) : dur);
	endfunction

	function void enter_mode(input logic [MODE_W-1:0] nxt);
		if (nxt != cur_mode) begin
			if (cur_mode == MODE_ACT) begin
				relay_on = 1'b0;
				stop_pulse = 1'b1;
			end
			cur_mode = nxt;
			ms_in_mode = '0;
			if (nxt == MODE_SPIN) begin
				blink_ms = '0;
				blink_on = 1'b0;
			end else if (nxt == MODE_ACT) begin
				relay_on = 1'b0;
				start_pulse = 1'b1;
			end
		end
	endfunction

	function result_t advance_one_ms(input logic emf, input logic ovr);
		logic [TIME_W-1:0] relay_at;
		result_t r;
		start_pulse = 1'b0;
		stop_pulse = 1'b0;
		if (ms_in_mode != TIME_MAX)
			ms_in_mode = ms_in_mode + 1'b1;
		if (cur_mode == MODE_SPIN) begin
			if (timer_hits(ms_in_mode, TIME_W'(spindown_cfg))) begin
				enter_mode(MODE_ACT);
			end else begin
				blink_ms = blink_ms + 1'b1;
				if (blink_ms >= BLINK_PERIOD_MS) begin
					blink_ms = '0;
					blink_on = ~blink_on;
				end
			end
		end else if (cur_mode == MODE_ACT) begin
			relay_at = TIME_W'(music_cfg) + RELAY_GAP_MS;
			if (timer_hits(ms_in_mode, TIME_W'(music_cfg)))
				stop_pulse = 1'b1;
			if (timer_hits(ms_in_mode, relay_at))
				relay_on = 1'b1;
			if (timer_hits(ms_in_mode, relay_at + TIME_W'(relay_on_cfg))) begin
				run_pending = 1'b0;
				enter_mode(MODE_LISTEN);
			end
		end
		if (ovr)
			enter_mode(MODE_ACT);
		case (cur_mode)
			MODE_LISTEN: begin
				if (emf)
					enter_mode(MODE_EMF);
			end
			MODE_EMF: begin
				if (!emf) begin
					if (ms_in_mode > TIME_W'(min_detect_cfg)) begin
						run_pending = 1'b1;
						enter_mode(MODE_SPIN);
					end else if (run_pending) begin
						enter_mode(MODE_SPIN);
					end else begin
						enter_mode(MODE_LISTEN);
					end
				end
			end
			default: begin
				if (emf)
					enter_mode(MODE_EMF);
			end
		endcase
		r.mode = cur_mode;
		r.power_led = (cur_mode == MODE_LISTEN) || (cur_mode == MODE_SPIN);
		r.trigger_led = (cur_mode == MODE_SPIN) ? blink_on : (cur_mode != MODE_LISTEN);
		r.relays_on = relay_on;
		r.music_start = start_pulse;
		r.music_stop = stop_pulse;
		r.volume = start_pulse ? volume_cfg : '0;
		return r;
	endfunction

	function void load_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DUR_W-1:0] data);
		case (idx)
			REG_MIN_DETECT: min_detect_cfg = data;
			REG_SPINDOWN:   spindown_cfg = data;
			REG_MUSIC:      music_cfg = data;
			REG_RELAY_ON:   relay_on_cfg = data;
			REG_VOLUME:     volume_cfg = data[VOL_W-1:0];
			default: ;
		endcase
	endfunction

	task automatic cmp_field(input string name, input logic [4:0] exp_v, input logic [4:0] got_v);
		if (got_v !== exp_v) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, exp_v, got_v);
			errors++;
		end
	endtask

	task automatic push_tick(input logic e, input logic o);
		item_t it;
		it.emf_present = e;
		it.override_press = o;
		tick_q.push_back(it);
		ticks_made++;
	endtask

	task automatic settle();
		do @(posedge clk);
		while (tick_q.size() != 0 || item_valid || tick_out_q.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DUR_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		load_reg(idx, data);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Bursts of EMF followed by quiet stretches, short or long enough to let
	// the spindown and activation timers run out, mixed with noise.
	task automatic run_phase(input logic [DUR_W-1:0] md, input logic [DUR_W-1:0] sp,
			input logic [DUR_W-1:0] mu, input logic [DUR_W-1:0] ro,
			input logic [DUR_W-1:0] vw, input int n, input int max_on,
			input int short_off, input int long_off, input int ovr_pm, input int idle);
		int target;
		int len;
		settle();
		write_reg(REG_MIN_DETECT, md);
		write_reg(REG_SPINDOWN, sp);
		write_reg(REG_MUSIC, mu);
		write_reg(REG_RELAY_ON, ro);
		write_reg(REG_VOLUME, vw);
		idle_pct = idle;
		target = ticks_made + n;
		while (ticks_made < target) begin
			if ($urandom_range(9) == 0) begin
				len = $urandom_range(16, 1);
				repeat (len) push_tick(1'($urandom_range(1)), ($urandom_range(999) < ovr_pm));
			end else begin
				len = $urandom_range(max_on, 1);
				repeat (len) push_tick(1'b1, ($urandom_range(999) < ovr_pm));
				if ($urandom_range(9) < 7)
					len = $urandom_range(short_off, 1);
				else
					len = $urandom_range(long_off, long_off / 2);
				repeat (len) push_tick(1'b0, ($urandom_range(999) < ovr_pm));
			end
		end
	endtask

	always @(negedge clk) begin
		if (!item_valid || item_taken) begin
			item_taken = 1'b0;
			if (arst_n && tick_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
				next_tick = tick_q.pop_front();
				item_valid <= 1'b1;
				emf_present <= next_tick.emf_present;
				override_press <= next_tick.override_press;
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (!hold_done && results_seen >= HOLD_AFTER_RESULTS) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left != 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(99) < idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && item_valid && !item_stall) begin
			tick_out_q.push_back(advance_one_ms(emf_present, override_press));
			item_taken = 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid === 1'b1 && !result_stall) begin
			results_seen++;
			if (tick_out_q.size() == 0) begin
				$display("%0t: result transaction with no tick outstanding", $time);
				errors++;
			end else begin
				want = tick_out_q.pop_front();
				cmp_field("mode", want.mode, mode);
				cmp_field("power_led", want.power_led, power_led);
				cmp_field("trigger_led", want.trigger_led, trigger_led);
				cmp_field("relays_on", want.relays_on, relays_on);
				cmp_field("music_start", want.music_start, music_start);
				cmp_field("music_stop", want.music_stop, music_stop);
				cmp_field("volume", want.volume, volume);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("[emf_triggered_activation_sequencer] ERROR");
			$finish;
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Blip to listening, override with music start, override ignored while
		// activating, EMF abort with music stop, both pulses in one tick.
		push_tick(1'b0, 1'b0);
		push_tick(1'b1, 1'b0);
		push_tick(1'b1, 1'b0);
		push_tick(1'b0, 1'b0);
		push_tick(1'b0, 1'b1);
		push_tick(1'b0, 1'b1);
		push_tick(1'b0, 1'b0);
		push_tick(1'b1, 1'b0);
		push_tick(1'b0, 1'b0);
		push_tick(1'b1, 1'b1);
		push_tick(1'b1, 1'b1);
		push_tick(1'b0, 1'b0);
		push_tick(1'b0, 1'b1);
		push_tick(1'b1, 1'b0);
		push_tick(1'b0, 1'b0);

		run_phase(20'd0, 20'd0, 20'd0, 20'd0, 20'h00000, 20, 4, 6, 40, 50, 17);

		// A solid detection, then quiet long enough for spindown, music stop,
		// the relay gap and the relay run, all without idling.
		run_phase(20'd3, 20'd5, 20'd2, 20'd4, 20'd30, 10, 8, 12, 12, 2, 0);
		repeat (6) push_tick(1'b1, 1'b0);
		repeat (515) push_tick(1'b0, 1'b0);

		settle();
		write_reg(REG_SPARE, 20'h5A5A5);
		run_phase(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 15, 6, 6, 10, 30, 17);
		run_phase(20'd2, 20'd20, 20'd1, 20'd0, 20'hA5A47, 15, 5, 10, 30, 1, 17);
		run_phase(20'd1, 20'd30, 20'd0, 20'd1, 20'h0000F, 15, 6, 10, 40, 1, 17);
		run_phase(20'd6, 20'd40, 20'd10, 20'd20, 20'd20, 15, 12, 20, 50, 5, 17);

		settle();
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("[emf_triggered_activation_sequencer] OK");
		else
			$display("[emf_triggered_activation_sequencer] ERROR");
		$finish;
	end

endmodule
